// ===== rtl/core/lcm_pkg.sv =====
// Shared types and constants for the least common multiple block.
`timescale 1ns / 1ps
`default_nettype none

package lcm_pkg;

  // Operand width actually used by the datapath.
  localparam int OP_W  = 16;
  localparam int LOG_W = $clog2(OP_W);

  typedef struct packed {
    logic [15:0] first_operand;
    logic [15:0] second_operand;
  } in_item_t;

  typedef struct packed {
    logic [31:0] lcm_value;
    logic        zero_operand_error;
  } out_item_t;

  // Controller to datapath.
  typedef struct packed {
    logic load;
    logic gcd_step;
    logic div_load;
    logic div_step;
    logic mul;
  } lcm_cmd_t;

  // Datapath to controller.
  typedef struct packed {
    logic in_zero;
    logic gcd_eq;
    logic div_last;
  } lcm_sts_t;

endpackage

`default_nettype wire

// ===== rtl/core/lcm_ctrl.sv =====
// Sequencer for load, binary GCD, division, multiply and result strobe.
`timescale 1ns / 1ps
`default_nettype none

module lcm_ctrl
  import lcm_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     start,
  output logic          busy,
  output logic          out_valid,
  output lcm_cmd_t      cmd,
  input  wire lcm_sts_t sts
);

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_GCD  = 5'b00010,
    S_DIV  = 5'b00100,
    S_MUL  = 5'b01000,
    S_DONE = 5'b10000
  } state_t;

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          cmd.load  = 1'b1;
          // a zero operand skips straight to the result
          state_nxt = sts.in_zero ? S_DONE : S_GCD;
        end
      end
      S_GCD: begin
        if (sts.gcd_eq) begin
          cmd.div_load = 1'b1;
          state_nxt    = S_DIV;
        end else begin
          cmd.gcd_step = 1'b1;
        end
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        if (sts.div_last) begin
          state_nxt = S_MUL;
        end
      end
      S_MUL: begin
        cmd.mul   = 1'b1;
        state_nxt = S_DONE;
      end
      S_DONE: begin
        state_nxt = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  assign busy      = (state_r != S_IDLE);
  assign out_valid = (state_r == S_DONE);

endmodule

`default_nettype wire

// ===== rtl/core/lcm_dpath.sv =====
// Datapath: binary GCD, restoring divider and final multiplier.
`timescale 1ns / 1ps
`default_nettype none

module lcm_dpath
  import lcm_pkg::*;
(
  input  wire logic     clk,
  input  wire in_item_t in_data,
  input  wire lcm_cmd_t cmd,
  output lcm_sts_t      sts,
  output out_item_t     out_data
);

  logic [OP_W-1:0]   a_in, b_in;
  logic [OP_W-1:0]   a_r, b_r;
  logic [OP_W-1:0]   u_r, u_nxt, v_r, v_nxt;
  logic [LOG_W-1:0]  k_r, k_nxt;
  logic [OP_W-1:0]   g_r;
  logic [OP_W-1:0]   rem_r, quo_r;
  logic [LOG_W-1:0]  cnt_r;
  logic [2*OP_W-1:0] prod_r;
  logic              err_r;
  logic [OP_W:0]     rem_sh, diff;

  assign a_in = OP_W'(in_data.first_operand);
  assign b_in = OP_W'(in_data.second_operand);

  assign sts.in_zero  = (a_in == '0) || (b_in == '0);
  assign sts.gcd_eq   = (u_r == v_r);
  assign sts.div_last = (cnt_r == '0);

  // One binary GCD step; the difference of two odd values is even.
  always_comb begin
    u_nxt = u_r;
    v_nxt = v_r;
    k_nxt = k_r;
    if (!u_r[0] && !v_r[0]) begin
      u_nxt = u_r >> 1;
      v_nxt = v_r >> 1;
      k_nxt = k_r + 1'b1;
    end else if (!u_r[0]) begin
      u_nxt = u_r >> 1;
    end else if (!v_r[0]) begin
      v_nxt = v_r >> 1;
    end else if (u_r > v_r) begin
      u_nxt = (u_r - v_r) >> 1;
    end else begin
      v_nxt = (v_r - u_r) >> 1;
    end
  end

  // Restoring division of a by g, one quotient bit per cycle.
  assign rem_sh = {rem_r, quo_r[OP_W-1]};
  assign diff   = rem_sh - {1'b0, g_r};

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      a_r   <= a_in;
      b_r   <= b_in;
      u_r   <= a_in;
      v_r   <= b_in;
      k_r   <= '0;
      err_r <= sts.in_zero;
    end
    if (cmd.gcd_step) begin
      u_r <= u_nxt;
      v_r <= v_nxt;
      k_r <= k_nxt;
    end
    if (cmd.div_load) begin
      g_r   <= u_r << k_r;
      rem_r <= '0;
      quo_r <= a_r;
      cnt_r <= LOG_W'(OP_W - 1);
    end
    if (cmd.div_step) begin
      if (!diff[OP_W]) begin
        rem_r <= diff[OP_W-1:0];
      end else begin
        rem_r <= rem_sh[OP_W-1:0];
      end
      quo_r <= {quo_r[OP_W-2:0], ~diff[OP_W]};
      cnt_r <= cnt_r - 1'b1;
    end
    if (cmd.mul) begin
      prod_r <= {{OP_W{1'b0}}, quo_r} * {{OP_W{1'b0}}, b_r};
    end
  end

  assign out_data.lcm_value          = err_r ? 32'd0 : 32'(prod_r);
  assign out_data.zero_operand_error = err_r;

endmodule

`default_nettype wire

// ===== rtl/core/lcm_two_naturals.sv =====
// Top level of the least common multiple block.
//
// Accepts a pair of operands when start is high and busy is low, and returns
// lcm(a, b) = (a / gcd(a, b)) * b on out_data with out_valid high for exactly
// one cycle; the receiver must take it then. A zero operand gives 0 with the
// error flag set, in the cycle right after the item is taken. Otherwise an
// item passes through a binary GCD loop of one step per cycle (the number of
// steps depends on the operand values), a restoring divider, the multiply
// state and the result state. busy stays high until the result has been
// shown, so one item is in flight at a time.
`timescale 1ns / 1ps
`default_nettype none

module lcm_two_naturals
  import lcm_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     start,
  output logic          busy,
  input  wire in_item_t in_data,
  output logic          out_valid,
  output out_item_t     out_data
);

  lcm_cmd_t cmd;
  lcm_sts_t sts;

  lcm_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .out_valid (out_valid),
    .cmd       (cmd),
    .sts       (sts)
  );

  lcm_dpath u_dpath (
    .clk      (clk),
    .in_data  (in_data),
    .cmd      (cmd),
    .sts      (sts),
    .out_data (out_data)
  );

endmodule

`default_nettype wire

// ===== rtl/core/lcm_checker.sv =====
// Port-level checks for the least common multiple block, bound to the top.
`timescale 1ns / 1ps
`default_nettype none

module lcm_checker
  import lcm_pkg::*;
(
  input wire logic      clk,
  input wire logic      rst_n,
  input wire logic      start,
  input wire logic      busy,
  input wire logic      out_valid,
  input wire out_item_t out_data
);

  // result strobe lasts one cycle
  a_strobe_single: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid)
    else $error("out_valid held for more than one cycle");

  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy)
    else $error("busy not raised after an accepted item");

  // a result only appears while an item is in flight
  a_result_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> busy)
    else $error("result shown while idle");

  a_error_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_data.zero_operand_error) |-> (out_data.lcm_value == 32'd0))
    else $error("error result with nonzero value");

endmodule

bind lcm_two_naturals lcm_checker u_lcm_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .start     (start),
  .busy      (busy),
  .out_valid (out_valid),
  .out_data  (out_data)
);

`default_nettype wire

// ===== tb/testbench.sv =====
// Self-checking testbench for the least common multiple block.
`timescale 1ns / 1ps

module testbench;
  import lcm_pkg::*;

  // Holds the results still owed by the block, in order of acceptance.
  class lcm_tracker;
    out_item_t owed[$];
    int unsigned errors;

    function new();
      errors = 0;
    endfunction

    // Euclid on the masked operands, then (a / gcd) * b, kept to 32 bits.
    function out_item_t lcm_predict(in_item_t p);
      logic [63:0] a, b, x, y, r, l;
      out_item_t res;
      a = 64'(p.first_operand) & ((64'd1 << OP_W) - 64'd1);
      b = 64'(p.second_operand) & ((64'd1 << OP_W) - 64'd1);
      if (a == 64'd0 || b == 64'd0) begin
        res.lcm_value = 32'd0;
        res.zero_operand_error = 1'b1;
      end else begin
        x = a;
        y = b;
        while (y != 64'd0) begin
          r = x % y;
          x = y;
          y = r;
        end
        l = (a / x) * b;
        res.lcm_value = l[31:0];
        res.zero_operand_error = 1'b0;
      end
      return res;
    endfunction

    function void note_pair(in_item_t p);
      owed.push_back(lcm_predict(p));
    endfunction

    function void check_result(out_item_t got);
      out_item_t want;
      if (owed.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual lcm %h err %b",
                 $time, got.lcm_value, got.zero_operand_error);
        errors++;
        return;
      end
      want = owed.pop_front();
      if (got.lcm_value !== want.lcm_value) begin
        $display("%0t: lcm_value mismatch, expected %h, actual %h",
                 $time, want.lcm_value, got.lcm_value);
        errors++;
      end
      if (got.zero_operand_error !== want.zero_operand_error) begin
        $display("%0t: zero_operand_error mismatch, expected %b, actual %b",
                 $time, want.zero_operand_error, got.zero_operand_error);
        errors++;
      end
    endfunction

    function int unsigned outstanding();
      return owed.size();
    endfunction
  endclass

  logic      clk = 1'b0;
  logic      rst_n;
  logic      start;
  logic      busy;
  in_item_t  in_data;
  logic      out_valid;
  out_item_t out_data;

  lcm_tracker tracker = new();

  lcm_two_naturals uut (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (start),
    .busy     (busy),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_data (out_data)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    if (rst_n && out_valid) begin
      tracker.check_result(out_data);
    end
  end

  function automatic in_item_t pair(logic [15:0] a, logic [15:0] b);
    in_item_t p;
    p.first_operand = a;
    p.second_operand = b;
    return p;
  endfunction

  // Mostly back to back or short gaps, now and then a long one.
  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 80);
  endfunction

  function automatic in_item_t rand_pair();
    int unsigned r, g, k;
    logic [15:0] a, b;
    r = $urandom_range(0, 99);
    a = 16'($urandom);
    b = 16'($urandom);
    if (r < 40) begin
      // fully random operands
    end else if (r < 55) begin
      a = 16'($urandom_range(1, 255));
      b = 16'($urandom_range(1, 255));
    end else if (r < 70) begin
      // shared factor g, so the gcd is a multiple of g
      g = $urandom_range(1, 255);
      a = 16'(g * $urandom_range(1, 255));
      b = 16'(g * $urandom_range(1, 255));
    end else if (r < 78) begin
      a = 16'(1) << $urandom_range(0, 15);
      if ($urandom_range(0, 1)) begin
        b = 16'(1) << $urandom_range(0, 15);
      end
    end else if (r < 84) begin
      b = a;
    end else if (r < 90) begin
      b = 16'($urandom_range(1, 65535));
      k = $urandom_range(1, 65535 / b);
      a = 16'(k * b);
    end else if (r < 95) begin
      a = 16'($urandom_range(65000, 65535));
      b = 16'($urandom_range(65000, 65535));
    end else begin
      case ($urandom_range(0, 2))
        0: a = 16'd0;
        1: b = 16'd0;
        default: begin
          a = 16'd0;
          b = 16'd0;
        end
      endcase
    end
    if ($urandom_range(0, 1)) begin
      return pair(b, a);
    end
    return pair(a, b);
  endfunction

  // Holds start high until the item is taken; start stays high afterwards
  // so a following item with no gap is taken as soon as busy is low.
  task automatic send_pair(in_item_t p, int unsigned gap);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start <= 1'b1;
    in_data <= p;
    do @(posedge clk); while (busy);
    tracker.note_pair(p);
  endtask

  task automatic drain();
    while (tracker.outstanding() != 0) @(posedge clk);
  endtask

  initial begin
    int unsigned gap;
    rst_n <= 1'b0;
    start <= 1'b0;
    in_data <= '0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // corner cases: zeros, ones, extremes, primes, shared factors
    send_pair(pair(16'h0000, 16'h0000), 0);
    send_pair(pair(16'h0000, 16'h0005), 0);
    send_pair(pair(16'hffff, 16'h0000), 0);
    send_pair(pair(16'h0001, 16'h0001), 0);
    send_pair(pair(16'hffff, 16'hffff), 0);
    send_pair(pair(16'hffff, 16'hfffe), 0);
    send_pair(pair(16'h0001, 16'hffff), 0);
    send_pair(pair(16'hffff, 16'h0001), 0);
    send_pair(pair(16'h8000, 16'h8000), 0);
    send_pair(pair(16'h8000, 16'h0001), 0);
    send_pair(pair(16'h8000, 16'hffff), 0);
    send_pair(pair(16'd65521, 16'd65519), 0);
    send_pair(pair(16'd12, 16'd18), 0);
    send_pair(pair(16'd7, 16'd7), 0);
    send_pair(pair(16'h5555, 16'haaaa), 0);
    send_pair(pair(16'd1, 16'd2), 0);
    send_pair(pair(16'h0000, 16'h0001), 0);
    send_pair(pair(16'd46368, 16'd28657), 0);

    // wait for every result before going on
    start <= 1'b0;
    drain();

    for (int i = 0; i < 1200; i++) begin
      gap = pick_gap();
      if (i >= 300 && i < 360) gap = 0;
      send_pair(rand_pair(), gap);
      if (i == 700) begin
        start <= 1'b0;
        drain();
      end
    end
    start <= 1'b0;

    drain();
    repeat (60) @(posedge clk);
    if (tracker.errors == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  initial begin
    #10_000_000;
    $display("timeout with %0d results outstanding", tracker.outstanding());
    $display("*** FAILED ***");
    $finish;
  end

endmodule

// ===== lcm_two_naturals.f =====
rtl/core/lcm_pkg.sv
rtl/core/lcm_ctrl.sv
rtl/core/lcm_dpath.sv
rtl/core/lcm_two_naturals.sv
rtl/core/lcm_checker.sv
tb/testbench.sv
